[design/msa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package msa_pkg;

    localparam int SECTOR_BYTES  = 512;
    localparam int SECTOR_SHIFT  = $clog2(SECTOR_BYTES);
    localparam int MAX_SECTORS   = 18;
    localparam int SPT_W         = 5;
    localparam int TRACK_W       = 14;
    localparam int OFFSET_W      = 23;
    localparam int FILE_W        = 24;
    localparam int REC_W         = 16;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 24;

    localparam logic [7:0] RLE_MARKER = 8'hE5;

    localparam logic [SPT_W-1:0]  RST_SPT          = 5'd9;
    localparam logic [1:0]        RST_SIDE_COUNT   = 2'd2;
    localparam logic [7:0]        RST_FIRST_TRACK  = 8'd0;
    localparam logic [7:0]        RST_LAST_TRACK   = 8'd79;
    localparam logic [FILE_W-1:0] RST_RECORD_BYTES = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SECTORS_PER_TRACK = 3'd0,
        CFG_SIDE_COUNT        = 3'd1,
        CFG_FIRST_TRACK       = 3'd2,
        CFG_LAST_TRACK        = 3'd3,
        CFG_RECORD_BYTES      = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [SPT_W-1:0]  sectors_per_track;
        logic [1:0]        side_count;
        logic [7:0]        first_track;
        logic [7:0]        last_track;
        logic [FILE_W-1:0] record_bytes;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
    } t_in_item;

    typedef struct packed {
        logic [7:0]          fill_value;
        logic [TRACK_W-1:0]  fill_length;
        logic [OFFSET_W-1:0] image_offset;
        logic [7:0]          track_number;
        logic                side_number;
    } t_out_item;

    // run as queued between parser and output stage, offset not yet summed
    typedef struct packed {
        logic [7:0]          fill_value;
        logic [TRACK_W-1:0]  fill_length;
        logic [OFFSET_W-1:0] track_base;
        logic [TRACK_W-1:0]  fill_start;
        logic [7:0]          track_number;
        logic                side_number;
    } t_run_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

[design/msa_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module msa_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire msa_pkg::t_cfg     i_cfg,
    input  wire logic              i_valid,
    input  wire msa_pkg::t_in_item i_item,
    output logic                   o_wr,
    output msa_pkg::t_run_cmd      o_cmd
);

    typedef enum logic [1:0] {
        REC_LEN_HI,
        REC_LEN_LO,
        REC_BODY
    } t_rec_phase;

    typedef enum logic [1:0] {
        RUN_IDLE,
        RUN_VALUE,
        RUN_COUNT_HI,
        RUN_COUNT_LO
    } t_run_phase;

    t_rec_phase                         r_phase, c_phase, n_phase;
    t_run_phase                         r_run, c_run, n_run;
    logic [msa_pkg::REC_W-1:0]          r_len, c_len, n_len;
    logic [msa_pkg::REC_W-1:0]          r_pos, c_pos, n_pos;
    logic [msa_pkg::TRACK_W-1:0]        r_fill, c_fill, n_fill;
    logic                               r_raw, c_raw, n_raw;
    logic [7:0]                         r_held, c_held, n_held;
    logic [7:0]                         r_cnt_hi, c_cnt_hi, n_cnt_hi;
    logic [7:0]                         r_track, c_track, n_track;
    logic                               r_side, c_side, n_side;
    logic [msa_pkg::OFFSET_W-1:0]       r_base, c_base, n_base;
    logic [msa_pkg::FILE_W-1:0]         r_fpos, c_fpos, n_fpos;
    logic                               r_stopped, c_stopped, n_stopped;

    logic [msa_pkg::SPT_W-1:0]          spt_eff;
    logic                               two_sides;
    logic [msa_pkg::TRACK_W-1:0]        trk_bytes;
    logic [msa_pkg::REC_W-1:0]          len_full;
    logic [msa_pkg::FILE_W-1:0]         fpos_inc;
    logic [8:0]                         rec_index;
    logic [msa_pkg::TRACK_W-1:0]        index_prod;
    logic [msa_pkg::REC_W:0]            pos_inc;
    logic [msa_pkg::REC_W-1:0]          count;
    logic [msa_pkg::TRACK_W-1:0]        room;
    logic [msa_pkg::TRACK_W-1:0]        run_len;
    logic                               do_next;
    logic                               emit;
    logic [7:0]                         emit_value;
    logic [msa_pkg::TRACK_W-1:0]        emit_len;

    // effective geometry, saturated into the legal range
    always_comb begin
        if (i_cfg.sectors_per_track == '0) begin
            spt_eff = msa_pkg::SPT_W'(1);
        end else if (i_cfg.sectors_per_track > msa_pkg::SPT_W'(msa_pkg::MAX_SECTORS)) begin
            spt_eff = msa_pkg::SPT_W'(msa_pkg::MAX_SECTORS);
        end else begin
            spt_eff = i_cfg.sectors_per_track;
        end
    end

    assign two_sides = i_cfg.side_count[1];
    assign trk_bytes = msa_pkg::TRACK_W'(spt_eff) << msa_pkg::SECTOR_SHIFT;

    always_comb begin
        // a first byte restarts parsing from a clean state
        if (i_item.first) begin
            c_phase   = REC_LEN_HI;
            c_run     = RUN_IDLE;
            c_len     = '0;
            c_pos     = '0;
            c_fill    = '0;
            c_raw     = 1'b0;
            c_held    = '0;
            c_cnt_hi  = '0;
            c_track   = i_cfg.first_track;
            c_side    = 1'b0;
            c_base    = '0;
            c_fpos    = '0;
            c_stopped = (i_cfg.last_track < i_cfg.first_track);
        end else begin
            c_phase   = r_phase;
            c_run     = r_run;
            c_len     = r_len;
            c_pos     = r_pos;
            c_fill    = r_fill;
            c_raw     = r_raw;
            c_held    = r_held;
            c_cnt_hi  = r_cnt_hi;
            c_track   = r_track;
            c_side    = r_side;
            c_base    = r_base;
            c_fpos    = r_fpos;
            c_stopped = r_stopped;
        end

        n_phase   = c_phase;
        n_run     = c_run;
        n_len     = c_len;
        n_pos     = c_pos;
        n_fill    = c_fill;
        n_raw     = c_raw;
        n_held    = c_held;
        n_cnt_hi  = c_cnt_hi;
        n_track   = c_track;
        n_side    = c_side;
        n_base    = c_base;
        n_fpos    = c_fpos;
        n_stopped = c_stopped;

        len_full   = {c_len[15:8], i_item.data_byte};
        fpos_inc   = c_fpos + msa_pkg::FILE_W'(1);
        rec_index  = (two_sides ? {c_track, 1'b0} : {1'b0, c_track}) + 9'(c_side);
        index_prod = msa_pkg::TRACK_W'(rec_index * spt_eff);
        pos_inc    = {1'b0, c_pos} + 17'd1;
        count      = {c_cnt_hi, i_item.data_byte};
        room       = trk_bytes - c_fill;
        run_len    = (count < {2'b0, room}) ? count[msa_pkg::TRACK_W-1:0] : room;

        do_next    = 1'b0;
        emit       = 1'b0;
        emit_value = i_item.data_byte;
        emit_len   = msa_pkg::TRACK_W'(1);

        if (!c_stopped) begin
            case (c_phase)
                REC_LEN_HI: begin
                    if ({1'b0, c_fpos} + 25'd2 > {1'b0, i_cfg.record_bytes}) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_len   = {i_item.data_byte, 8'h00};
                        n_fpos  = fpos_inc;
                        n_phase = REC_LEN_LO;
                    end
                end
                REC_LEN_LO: begin
                    n_len  = len_full;
                    n_fpos = fpos_inc;
                    if ({1'b0, fpos_inc} + 25'(len_full) > {1'b0, i_cfg.record_bytes}) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_base = {index_prod[msa_pkg::OFFSET_W-msa_pkg::SECTOR_SHIFT-1:0],
                                  msa_pkg::SECTOR_SHIFT'(0)};
                        n_fill = '0;
                        n_pos  = '0;
                        n_run  = RUN_IDLE;
                        n_raw  = (len_full == {2'b0, trk_bytes});
                        if (len_full == '0) begin
                            do_next = 1'b1;
                        end else begin
                            n_phase = REC_BODY;
                        end
                    end
                end
                REC_BODY: begin
                    n_fpos = fpos_inc;
                    n_pos  = pos_inc[msa_pkg::REC_W-1:0];
                    if (c_fill < trk_bytes) begin
                        if (c_raw) begin
                            emit = 1'b1;
                        end else begin
                            case (c_run)
                                RUN_IDLE: begin
                                    if (i_item.data_byte == msa_pkg::RLE_MARKER &&
                                        {1'b0, c_pos} + 17'd3 < {1'b0, c_len}) begin
                                        n_run = RUN_VALUE;
                                    end else begin
                                        emit = 1'b1;
                                    end
                                end
                                RUN_VALUE: begin
                                    n_held = i_item.data_byte;
                                    n_run  = RUN_COUNT_HI;
                                end
                                RUN_COUNT_HI: begin
                                    n_cnt_hi = i_item.data_byte;
                                    n_run    = RUN_COUNT_LO;
                                end
                                RUN_COUNT_LO: begin
                                    n_run      = RUN_IDLE;
                                    emit_value = c_held;
                                    emit_len   = run_len;
                                    emit       = (run_len != '0);
                                end
                                default: begin
                                    n_run = RUN_IDLE;
                                end
                            endcase
                        end
                    end
                    if (emit) begin
                        n_fill = c_fill + emit_len;
                    end
                    if (pos_inc >= {1'b0, c_len}) begin
                        do_next = 1'b1;
                    end
                end
                default: begin
                    n_phase = REC_LEN_HI;
                end
            endcase
        end

        // advance to the next side or track once a record is done, or stop after the last track
        if (do_next) begin
            n_phase = REC_LEN_HI;
            n_run   = RUN_IDLE;
            if (two_sides && !c_side) begin
                n_side = 1'b1;
            end else if (c_track >= i_cfg.last_track) begin
                n_stopped = 1'b1;
            end else begin
                n_track = c_track + 8'd1;
                n_side  = 1'b0;
            end
        end
    end

    assign o_wr                 = i_valid && emit;
    assign o_cmd.fill_value     = emit_value;
    assign o_cmd.fill_length    = emit_len;
    assign o_cmd.track_base     = c_base;
    assign o_cmd.fill_start     = c_fill;
    assign o_cmd.track_number   = c_track;
    assign o_cmd.side_number    = c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= REC_LEN_HI;
            r_run     <= RUN_IDLE;
            r_len     <= '0;
            r_pos     <= '0;
            r_fill    <= '0;
            r_raw     <= 1'b0;
            r_held    <= '0;
            r_cnt_hi  <= '0;
            r_track   <= '0;
            r_side    <= 1'b0;
            r_base    <= '0;
            r_fpos    <= '0;
            r_stopped <= 1'b1;
        end else if (i_valid) begin
            r_phase   <= n_phase;
            r_run     <= n_run;
            r_len     <= n_len;
            r_pos     <= n_pos;
            r_fill    <= n_fill;
            r_raw     <= n_raw;
            r_held    <= n_held;
            r_cnt_hi  <= n_cnt_hi;
            r_track   <= n_track;
            r_side    <= n_side;
            r_base    <= n_base;
            r_fpos    <= n_fpos;
            r_stopped <= n_stopped;
        end
    end

endmodule

`default_nettype wire

[design/msa_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module msa_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr,
    input  wire msa_pkg::t_run_cmd i_cmd,
    input  wire logic              i_rd,
    output msa_pkg::t_run_cmd      o_cmd,
    output msa_pkg::t_q_status     o_stat
);

    msa_pkg::t_run_cmd                r_mem [msa_pkg::FIFO_DEPTH];
    logic [msa_pkg::FIFO_PTR_W-1:0]   r_wr_ptr;
    logic [msa_pkg::FIFO_PTR_W-1:0]   r_rd_ptr;
    logic [msa_pkg::FIFO_CNT_W-1:0]   r_count;
    logic [msa_pkg::FIFO_CNT_W-1:0]   n_count;

    assign o_stat.full  = (r_count == msa_pkg::FIFO_CNT_W'(msa_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_cmd        = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_wr && !i_rd) begin
            n_count = r_count + msa_pkg::FIFO_CNT_W'(1);
        end else if (i_rd && !i_wr) begin
            n_count = r_count - msa_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + msa_pkg::FIFO_PTR_W'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + msa_pkg::FIFO_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_stat.full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd && o_stat.empty))
        else $error("queue read while empty");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr && !i_rd) |=> (r_count == $past(r_count) + msa_pkg::FIFO_CNT_W'(1)))
        else $error("queue count did not follow a lone write");

endmodule

`default_nettype wire

[design/msa_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module msa_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire msa_pkg::t_q_status i_stat,
    input  wire msa_pkg::t_run_cmd  i_cmd,
    output logic                    o_rd,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output msa_pkg::t_out_item      o_item
);

    logic                r_valid;
    msa_pkg::t_out_item  r_item;
    msa_pkg::t_out_item  n_item;
    logic                load;

    assign load = !r_valid || i_pop;
    assign o_rd = load && !i_stat.empty;

    // image offset is the record base plus what the track already holds
    always_comb begin
        n_item.fill_value   = i_cmd.fill_value;
        n_item.fill_length  = i_cmd.fill_length;
        n_item.image_offset = i_cmd.track_base + msa_pkg::OFFSET_W'(i_cmd.fill_start);
        n_item.track_number = i_cmd.track_number;
        n_item.side_number  = i_cmd.side_number;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_stat.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rd) begin
            r_item <= n_item;
        end
    end

    assign o_empty = !r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[design/msa_track_rle_decoder_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// msa track record decoder
// input channel: one file byte per transfer (push/full), starting with the first
// byte after the 10-byte header, flagged by first = 1; first restarts parsing
// result channel: one run per transfer (empty/pop) with its value, length,
// image offset, track and side; raw bytes and literals come out as length 1
// configuration: write-only register port, geometry and file size taken live;
// write only while idle (not enforced); only sectors per track is saturated
// throughput: one byte per cycle sustained; each byte yields at most one run,
// and the parser never waits on the back end unless the 4-entry run queue fills
// path: a run caused by a byte is written into the queue at the byte transfer,
// then into the output register once that register is free to take it
// stall: when pop stays low the output register holds, the queue fills and
// full rises; no run is ever dropped
// reset: queue and output empty, registers at their defaults, parser stopped
// until a byte with first set arrives
module msa_track_rle_decoder_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_wr_en,
    input  wire logic [msa_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [msa_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire msa_pkg::t_in_item                    i_in_item,
    output logic                                      empty,
    input  wire logic                                 pop,
    output msa_pkg::t_out_item                        o_out_item
);

    msa_pkg::t_cfg      r_cfg;
    msa_pkg::t_q_status q_stat;
    msa_pkg::t_run_cmd  front_cmd;
    msa_pkg::t_run_cmd  queue_cmd;
    logic               front_wr;
    logic               queue_rd;
    logic               in_xfer;

    // configuration registers, plain write port without read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sectors_per_track <= msa_pkg::RST_SPT;
            r_cfg.side_count        <= msa_pkg::RST_SIDE_COUNT;
            r_cfg.first_track       <= msa_pkg::RST_FIRST_TRACK;
            r_cfg.last_track        <= msa_pkg::RST_LAST_TRACK;
            r_cfg.record_bytes      <= msa_pkg::RST_RECORD_BYTES;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                msa_pkg::CFG_SECTORS_PER_TRACK: begin
                    r_cfg.sectors_per_track <= i_cfg_data[msa_pkg::SPT_W-1:0];
                end
                msa_pkg::CFG_SIDE_COUNT: begin
                    r_cfg.side_count <= i_cfg_data[1:0];
                end
                msa_pkg::CFG_FIRST_TRACK: begin
                    r_cfg.first_track <= i_cfg_data[7:0];
                end
                msa_pkg::CFG_LAST_TRACK: begin
                    r_cfg.last_track <= i_cfg_data[7:0];
                end
                msa_pkg::CFG_RECORD_BYTES: begin
                    r_cfg.record_bytes <= i_cfg_data[msa_pkg::FILE_W-1:0];
                end
                default: begin
                    // unused indexes are ignored
                end
            endcase
        end
    end

    // byte transfer: the parser advances only on an accepted byte
    assign in_xfer = push && !q_stat.full;
    assign full    = q_stat.full;

    // front end: record framing, rle parsing, clamping to track space
    msa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (in_xfer),
        .i_item  (i_in_item),
        .o_wr    (front_wr),
        .o_cmd   (front_cmd)
    );

    // short run queue decouples the parser from result stalls
    msa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_wr),
        .i_cmd   (front_cmd),
        .i_rd    (queue_rd),
        .o_cmd   (queue_cmd),
        .o_stat  (q_stat)
    );

    // back end: offset sum and output register
    msa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (q_stat),
        .i_cmd   (queue_cmd),
        .o_rd    (queue_rd),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire
